// ===== src/cpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Camera projection package
// Shared fixed-point types, limits, pipeline latencies, register and status
// codes, and the saturating adder used by the projection datapath.
// ----------------------------------------------------------------------------
package cpp_pkg;

    // Internal value: signed, 24 fraction bits, held in 64 bits.
    typedef logic signed [63:0] q_t;

    localparam int FRAC_BITS = 24;
    localparam q_t SAT_LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam q_t ONE_Q     = 64'sd16777216;

    // Latency of the multiplier and divider banks in cycles.
    localparam int MUL_LAT = 5;
    localparam int DIV_LAT = 67;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_FOCAL_X,
        REG_FOCAL_Y,
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_K1_K2,
        REG_K3_K4,
        REG_K5_K6,
        REG_P1_P2
    } reg_idx_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DEPTH = 2'd1,
        ST_CLAMP = 2'd2
    } status_t;

    // Saturated value with its overflow flag.
    typedef struct packed {
        logic sat;
        q_t   val;
    } sres_t;

    // Sign-extend a 32-bit field to the internal format.
    function automatic q_t sx32(logic [31:0] v);
        return q_t'({{32{v[31]}}, v});
    endfunction

    // Add two values that lie within the limit and clamp the sum to it.
    function automatic sres_t sat_add(q_t a, q_t b);
        q_t    s;
        sres_t r;
        s = a + b;
        r.sat = (s > SAT_LIM) || (s < -SAT_LIM);
        if (s > SAT_LIM)
        begin
            r.val = SAT_LIM;
        end
        else if (s < -SAT_LIM)
        begin
            r.val = -SAT_LIM;
        end
        else
        begin
            r.val = s;
        end
        return r;
    endfunction

endpackage

// ===== src/cpp_mul_bank.sv =====
// ----------------------------------------------------------------------------
// Pipelined fixed-point multiplier bank
// Several lanes of signed 64-bit products rounded to 24 fraction bits, half
// away from zero, and saturated. Each product is built from four 32x32
// partial products over five stages; a side word travels alongside.
// ----------------------------------------------------------------------------
module cpp_mul_bank #(
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  cpp_pkg::q_t [LANES-1:0]       a,
    input  cpp_pkg::q_t [LANES-1:0]       b,
    input  logic [SW-1:0]                 side_in,
    output logic                          out_valid,
    output cpp_pkg::q_t [LANES-1:0]       p,
    output logic [LANES-1:0]              sat,
    output logic [SW-1:0]                 side_out
);

    localparam int STAGES = cpp_pkg::MUL_LAT;
    localparam logic [127:0] RND = 128'(1) << (cpp_pkg::FRAC_BITS - 1);

    logic [STAGES-1:0]              valid_reg;
    logic [SW-1:0]                  side_reg [STAGES];
    logic [LANES-1:0]               neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [LANES-1:0][63:0]         ua_reg, ub_reg;
    logic [LANES-1:0][63:0]         ll_reg, lh_reg, hl_reg, hh_reg;
    logic [LANES-1:0][63:0]         ll3_reg, hh3_reg;
    logic [LANES-1:0][64:0]         mid_reg;
    logic [LANES-1:0][127:0]        prod_reg;
    cpp_pkg::q_t [LANES-1:0]        p_reg, p_next;
    logic [LANES-1:0]               sat_reg, sat_next;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // Side word delay line.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Stage 5 logic: detect overflow above 62 bits and restore the sign.
    always_comb
    begin
        cpp_pkg::q_t mag;
        for (int l = 0; l < LANES; l++)
        begin
            sat_next[l] = |prod_reg[l][127:86];
            mag = sat_next[l] ? cpp_pkg::SAT_LIM
                              : cpp_pkg::q_t'({2'b00, prod_reg[l][85:24]});
            p_next[l] = neg4_reg[l] ? -mag : mag;
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                // Stage 1: magnitudes and product sign.
                neg1_reg[l] <= a[l][63] ^ b[l][63];
                ua_reg[l]   <= a[l][63] ? 64'(-a[l]) : 64'(a[l]);
                ub_reg[l]   <= b[l][63] ? 64'(-b[l]) : 64'(b[l]);
                // Stage 2: four partial products.
                neg2_reg[l] <= neg1_reg[l];
                ll_reg[l]   <= 64'(ua_reg[l][31:0])  * 64'(ub_reg[l][31:0]);
                lh_reg[l]   <= 64'(ua_reg[l][31:0])  * 64'(ub_reg[l][63:32]);
                hl_reg[l]   <= 64'(ua_reg[l][63:32]) * 64'(ub_reg[l][31:0]);
                hh_reg[l]   <= 64'(ua_reg[l][63:32]) * 64'(ub_reg[l][63:32]);
                // Stage 3: sum of the cross terms.
                neg3_reg[l] <= neg2_reg[l];
                mid_reg[l]  <= 65'(lh_reg[l]) + 65'(hl_reg[l]);
                ll3_reg[l]  <= ll_reg[l];
                hh3_reg[l]  <= hh_reg[l];
                // Stage 4: full product plus rounding half.
                neg4_reg[l] <= neg3_reg[l];
                prod_reg[l] <= {hh3_reg[l], ll3_reg[l]} + {31'b0, mid_reg[l], 32'b0} + RND;
                // Stage 5: saturated, signed result.
                p_reg[l]    <= p_next[l];
                sat_reg[l]  <= sat_next[l];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];
    assign p         = p_reg;
    assign sat       = sat_reg;

endmodule

// ===== src/cpp_div_bank.sv =====
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider bank
// Several lanes of signed quotients with 24 fraction bits, rounded half away
// from zero and saturated. One restoring step per stage produces the 63-bit
// quotient; a side word travels alongside.
// ----------------------------------------------------------------------------
module cpp_div_bank #(
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  cpp_pkg::q_t [LANES-1:0]       n,
    input  cpp_pkg::q_t [LANES-1:0]       d,
    input  logic [SW-1:0]                 side_in,
    output logic                          out_valid,
    output cpp_pkg::q_t [LANES-1:0]       q,
    output logic [LANES-1:0]              sat,
    output logic [SW-1:0]                 side_out
);

    localparam int STAGES = cpp_pkg::DIV_LAT;
    localparam int STEPS  = 63;
    localparam int IBITS  = 38;
    localparam int FRACP  = cpp_pkg::FRAC_BITS + 1;

    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [63:0]       un;
        logic [63:0]       ud;
        logic [63:0]       rem;
        logic [STEPS-1:0]  quo;
    } dstate_t;

    logic [STAGES-1:0]          valid_reg;
    logic [SW-1:0]              side_reg [STAGES];
    logic [LANES-1:0]           neg1_reg;
    logic [LANES-1:0][63:0]     un1_reg, ud1_reg;
    dstate_t [LANES-1:0]        st_reg [STEPS+1];
    logic [LANES-1:0]           negr_reg, satr_reg;
    cpp_pkg::q_t [LANES-1:0]    magr_reg, q_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    // Side word delay line.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Stages 1 and 2: magnitudes, then the integer range check and the
    // starting remainder from the top bits of the scaled dividend.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                neg1_reg[l] <= n[l][63] ^ d[l][63];
                un1_reg[l]  <= n[l][63] ? 64'(-n[l]) : 64'(n[l]);
                ud1_reg[l]  <= d[l][63] ? 64'(-d[l]) : 64'(d[l]);
                st_reg[0][l].neg <= neg1_reg[l];
                st_reg[0][l].ovf <= {38'b0, un1_reg[l]} >= {ud1_reg[l], 38'b0};
                st_reg[0][l].un  <= un1_reg[l];
                st_reg[0][l].ud  <= ud1_reg[l];
                st_reg[0][l].rem <= {38'b0, un1_reg[l][63:IBITS]};
                st_reg[0][l].quo <= '0;
            end
        end
    end

    // One restoring step per stage, dividend bits from high to low.
    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        localparam int J = STEPS - k;
        logic [LANES-1:0]       nb;
        logic [LANES-1:0][63:0] t;

        if (J >= FRACP)
        begin : g_bit
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    nb[l] = st_reg[k-1][l].un[J-FRACP];
                end
            end
        end
        else
        begin : g_zero
            assign nb = '0;
        end

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                t[l] = {st_reg[k-1][l].rem[62:0], nb[l]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    st_reg[k][l] <= st_reg[k-1][l];
                    if (t[l] >= st_reg[k-1][l].ud)
                    begin
                        st_reg[k][l].rem <= t[l] - st_reg[k-1][l].ud;
                        st_reg[k][l].quo <= {st_reg[k-1][l].quo[STEPS-2:0], 1'b1};
                    end
                    else
                    begin
                        st_reg[k][l].rem <= t[l];
                        st_reg[k][l].quo <= {st_reg[k-1][l].quo[STEPS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Final stages: round the extra bit away, saturate, then restore sign.
    always_ff @(posedge clk)
    begin
        logic [63:0] qs;
        logic        s;
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                qs = 64'(st_reg[STEPS][l].quo) + 64'd1;
                s  = st_reg[STEPS][l].ovf | qs[63];
                negr_reg[l] <= st_reg[STEPS][l].neg;
                satr_reg[l] <= s;
                magr_reg[l] <= s ? cpp_pkg::SAT_LIM : cpp_pkg::q_t'({1'b0, qs[63:1]});
                q_reg[l]    <= negr_reg[l] ? -magr_reg[l] : magr_reg[l];
            end
        end
    end

    // The sat flag is one stage ahead of the quotient; delay it once more.
    logic [LANES-1:0] sat_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg <= satr_reg;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];
    assign q         = q_reg;
    assign sat       = sat_reg;

endmodule

// ===== src/camera_point_to_pixel_projection.sv =====
// Throughput: one point per cycle while the skid entry is empty; the two 67-stage dividers,
// one restoring step each, and six 5-stage multiplier banks set the depth.
// Stall: an output register plus one skid entry; the pipeline halts only when both are full.
// Reset: rst_n clears all valid bits and all configuration registers to zero.
// ----------------------------------------------------------------------------
// Camera point to pixel projection
// Divides X and Y by Z, applies rational radial and tangential distortion,
// scales by the focal lengths and adds the principal point, all in a
// stall-able fixed-point pipeline.
// ----------------------------------------------------------------------------
module camera_point_to_pixel_projection (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pixel_u [31:0], pixel_v [63:32]
    output logic [1:0]  m_tuser,   // proj_status [1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef cpp_pkg::q_t q_t;

    typedef struct packed {
        logic bad;
        logic sat;
        q_t px, py, pz;
        q_t x, y, xx, yy, xy, r2, xy2, xx2, yy2, tx, ty;
        q_t r4, k1r2, k4r2, p1xy2, p2xy2, p2tx, p1ty, r6, k2r4, k5r4, k3r6, k6r6;
        q_t na, nb, da, db, num, den, f, xf, yf, xa, ya, xp, yp, mu, mv, u, v, tu, tv;
    } ctx_t;

    typedef struct packed {
        logic [31:0]      u;
        logic [31:0]      v;
        cpp_pkg::status_t st;
    } res_t;

    localparam int CW = $bits(ctx_t);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] focal_x_reg, focal_y_reg, center_x_reg, center_y_reg;
    logic [63:0] k12_reg, k34_reg, k56_reg, p12_reg;
    cpp_pkg::reg_idx_t cfg_idx;

    assign cfg_idx = cpp_pkg::reg_idx_t'(paddr[5:3]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= '0;
            focal_y_reg  <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
            k12_reg      <= '0;
            k34_reg      <= '0;
            k56_reg      <= '0;
            p12_reg      <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_idx)
                cpp_pkg::REG_FOCAL_X:  focal_x_reg  <= pwdata[31:0];
                cpp_pkg::REG_FOCAL_Y:  focal_y_reg  <= pwdata[31:0];
                cpp_pkg::REG_CENTER_X: center_x_reg <= pwdata[31:0];
                cpp_pkg::REG_CENTER_Y: center_y_reg <= pwdata[31:0];
                cpp_pkg::REG_K1_K2:    k12_reg      <= pwdata;
                cpp_pkg::REG_K3_K4:    k34_reg      <= pwdata;
                cpp_pkg::REG_K5_K6:    k56_reg      <= pwdata;
                cpp_pkg::REG_P1_P2:    p12_reg      <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (cfg_idx)
            cpp_pkg::REG_FOCAL_X:  prdata = {32'b0, focal_x_reg};
            cpp_pkg::REG_FOCAL_Y:  prdata = {32'b0, focal_y_reg};
            cpp_pkg::REG_CENTER_X: prdata = {32'b0, center_x_reg};
            cpp_pkg::REG_CENTER_Y: prdata = {32'b0, center_y_reg};
            cpp_pkg::REG_K1_K2:    prdata = k12_reg;
            cpp_pkg::REG_K3_K4:    prdata = k34_reg;
            cpp_pkg::REG_K5_K6:    prdata = k56_reg;
            cpp_pkg::REG_P1_P2:    prdata = p12_reg;
            default:               prdata = '0;
        endcase
    end

    // Coefficients in the internal format.
    q_t k1, k2, k3, k4, k5, k6, p1, p2, fx, fy, cx, cy;
    assign k1 = cpp_pkg::sx32(k12_reg[31:0]);
    assign k2 = cpp_pkg::sx32(k12_reg[63:32]);
    assign k3 = cpp_pkg::sx32(k34_reg[31:0]);
    assign k4 = cpp_pkg::sx32(k34_reg[63:32]);
    assign k5 = cpp_pkg::sx32(k56_reg[31:0]);
    assign k6 = cpp_pkg::sx32(k56_reg[63:32]);
    assign p1 = cpp_pkg::sx32(p12_reg[31:0]);
    assign p2 = cpp_pkg::sx32(p12_reg[63:32]);
    assign fx = q_t'({24'b0, focal_x_reg, 8'b0});
    assign fy = q_t'({24'b0, focal_y_reg, 8'b0});
    assign cx = q_t'({24'b0, center_x_reg, 8'b0});
    assign cy = q_t'({24'b0, center_y_reg, 8'b0});

    // ------------------------------------------------------------------
    // Pipeline advance: the whole pipeline moves unless the skid is full.
    // ------------------------------------------------------------------
    logic en;
    logic skid_valid_reg, out_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Input stage.
    ctx_t c0_reg, c0_next;
    logic v0_reg;

    always_comb
    begin
        c0_next     = '0;
        c0_next.px  = cpp_pkg::sx32(s_tdata[31:0]);
        c0_next.py  = cpp_pkg::sx32(s_tdata[63:32]);
        c0_next.pz  = cpp_pkg::sx32(s_tdata[95:64]);
        c0_next.bad = s_tdata[95] || (s_tdata[95:64] == 32'd0);
    end

    // ------------------------------------------------------------------
    // Valid bits of the register stages in this module.
    // ------------------------------------------------------------------
    logic va1_reg, va2_reg, va3_reg, va4_reg, va5_reg, va6_reg;
    logic va7_reg, va8_reg, va9_reg;
    logic vd1, vm1, vm2, vm3, vm4, vd2, vm5, vm6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            va1_reg <= 1'b0;
            va2_reg <= 1'b0;
            va3_reg <= 1'b0;
            va4_reg <= 1'b0;
            va5_reg <= 1'b0;
            va6_reg <= 1'b0;
            va7_reg <= 1'b0;
            va8_reg <= 1'b0;
            va9_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg  <= s_tvalid;
            va1_reg <= vm1;
            va2_reg <= va1_reg;
            va3_reg <= vm4;
            va4_reg <= va3_reg;
            va5_reg <= vm5;
            va6_reg <= va5_reg;
            va7_reg <= vm6;
            va8_reg <= va7_reg;
            va9_reg <= va8_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divide X and Y by Z.
    // ------------------------------------------------------------------
    q_t [1:0]        d1_n, d1_d, d1_q;
    logic [1:0]      d1_sat;
    logic [CW-1:0]   d1_side;
    ctx_t            c1;

    assign d1_n = {c0_reg.py, c0_reg.px};
    assign d1_d = {c0_reg.pz, c0_reg.pz};

    cpp_div_bank #(.LANES(2), .SW(CW)) u_div_xy (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v0_reg),
        .n(d1_n), .d(d1_d), .side_in(CW'(c0_reg)),
        .out_valid(vd1), .q(d1_q), .sat(d1_sat), .side_out(d1_side)
    );

    always_comb
    begin
        c1     = ctx_t'(d1_side);
        c1.x   = d1_q[0];
        c1.y   = d1_q[1];
        c1.sat = c1.sat | (|d1_sat);
    end

    // ------------------------------------------------------------------
    // Squares and cross product.
    // ------------------------------------------------------------------
    q_t [2:0]        m1_a, m1_b, m1_p;
    logic [2:0]      m1_sat;
    logic [CW-1:0]   m1_side;
    ctx_t            c2;

    assign m1_a = {c1.y, c1.x, c1.x};
    assign m1_b = {c1.y, c1.y, c1.x};

    cpp_mul_bank #(.LANES(3), .SW(CW)) u_mul_sq (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vd1),
        .a(m1_a), .b(m1_b), .side_in(CW'(c1)),
        .out_valid(vm1), .p(m1_p), .sat(m1_sat), .side_out(m1_side)
    );

    always_comb
    begin
        c2     = ctx_t'(m1_side);
        c2.xx  = m1_p[0];
        c2.xy  = m1_p[1];
        c2.yy  = m1_p[2];
        c2.sat = c2.sat | (|m1_sat);
    end

    // r2 and the doubled terms.
    ctx_t a1_reg, a1_next;
    always_comb
    begin
        cpp_pkg::sres_t s0, s1, s2, s3;
        s0 = cpp_pkg::sat_add(c2.xx, c2.yy);
        s1 = cpp_pkg::sat_add(c2.xy, c2.xy);
        s2 = cpp_pkg::sat_add(c2.xx, c2.xx);
        s3 = cpp_pkg::sat_add(c2.yy, c2.yy);
        a1_next     = c2;
        a1_next.r2  = s0.val;
        a1_next.xy2 = s1.val;
        a1_next.xx2 = s2.val;
        a1_next.yy2 = s3.val;
        a1_next.sat = c2.sat | s0.sat | s1.sat | s2.sat | s3.sat;
    end

    // Tangential sums r2 + 2x^2 and r2 + 2y^2.
    ctx_t a2_reg, a2_next;
    always_comb
    begin
        cpp_pkg::sres_t s0, s1;
        s0 = cpp_pkg::sat_add(a1_reg.r2, a1_reg.xx2);
        s1 = cpp_pkg::sat_add(a1_reg.r2, a1_reg.yy2);
        a2_next     = a1_reg;
        a2_next.tx  = s0.val;
        a2_next.ty  = s1.val;
        a2_next.sat = a1_reg.sat | s0.sat | s1.sat;
    end

    // ------------------------------------------------------------------
    // r4, first-order radial terms and tangential products.
    // ------------------------------------------------------------------
    q_t [6:0]        m2_a, m2_b, m2_p;
    logic [6:0]      m2_sat;
    logic [CW-1:0]   m2_side;
    ctx_t            c3;

    assign m2_a = {p1, p2, p2, p1, k4, k1, a2_reg.r2};
    assign m2_b = {a2_reg.ty, a2_reg.tx, a2_reg.xy2, a2_reg.xy2,
                   a2_reg.r2, a2_reg.r2, a2_reg.r2};

    cpp_mul_bank #(.LANES(7), .SW(CW)) u_mul_r4 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(va2_reg),
        .a(m2_a), .b(m2_b), .side_in(CW'(a2_reg)),
        .out_valid(vm2), .p(m2_p), .sat(m2_sat), .side_out(m2_side)
    );

    always_comb
    begin
        c3       = ctx_t'(m2_side);
        c3.r4    = m2_p[0];
        c3.k1r2  = m2_p[1];
        c3.k4r2  = m2_p[2];
        c3.p1xy2 = m2_p[3];
        c3.p2xy2 = m2_p[4];
        c3.p2tx  = m2_p[5];
        c3.p1ty  = m2_p[6];
        c3.sat   = c3.sat | (|m2_sat);
    end

    // r6 and second-order radial terms.
    q_t [2:0]        m3_a, m3_b, m3_p;
    logic [2:0]      m3_sat;
    logic [CW-1:0]   m3_side;
    ctx_t            c4;

    assign m3_a = {k5, k2, c3.r4};
    assign m3_b = {c3.r4, c3.r4, c3.r2};

    cpp_mul_bank #(.LANES(3), .SW(CW)) u_mul_r6 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vm2),
        .a(m3_a), .b(m3_b), .side_in(CW'(c3)),
        .out_valid(vm3), .p(m3_p), .sat(m3_sat), .side_out(m3_side)
    );

    always_comb
    begin
        c4      = ctx_t'(m3_side);
        c4.r6   = m3_p[0];
        c4.k2r4 = m3_p[1];
        c4.k5r4 = m3_p[2];
        c4.sat  = c4.sat | (|m3_sat);
    end

    // Third-order radial terms.
    q_t [1:0]        m4_a, m4_b, m4_p;
    logic [1:0]      m4_sat;
    logic [CW-1:0]   m4_side;
    ctx_t            c5;

    assign m4_a = {k6, k3};
    assign m4_b = {c4.r6, c4.r6};

    cpp_mul_bank #(.LANES(2), .SW(CW)) u_mul_k6 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vm3),
        .a(m4_a), .b(m4_b), .side_in(CW'(c4)),
        .out_valid(vm4), .p(m4_p), .sat(m4_sat), .side_out(m4_side)
    );

    always_comb
    begin
        c5      = ctx_t'(m4_side);
        c5.k3r6 = m4_p[0];
        c5.k6r6 = m4_p[1];
        c5.sat  = c5.sat | (|m4_sat);
    end

    // Partial sums of numerator and denominator.
    ctx_t a3_reg, a3_next;
    always_comb
    begin
        cpp_pkg::sres_t s0, s1, s2, s3;
        s0 = cpp_pkg::sat_add(cpp_pkg::ONE_Q, c5.k1r2);
        s1 = cpp_pkg::sat_add(c5.k2r4, c5.k3r6);
        s2 = cpp_pkg::sat_add(cpp_pkg::ONE_Q, c5.k4r2);
        s3 = cpp_pkg::sat_add(c5.k5r4, c5.k6r6);
        a3_next     = c5;
        a3_next.na  = s0.val;
        a3_next.nb  = s1.val;
        a3_next.da  = s2.val;
        a3_next.db  = s3.val;
        a3_next.sat = c5.sat | s0.sat | s1.sat | s2.sat | s3.sat;
    end

    // Numerator and denominator.
    ctx_t a4_reg, a4_next;
    always_comb
    begin
        cpp_pkg::sres_t s0, s1;
        s0 = cpp_pkg::sat_add(a3_reg.na, a3_reg.nb);
        s1 = cpp_pkg::sat_add(a3_reg.da, a3_reg.db);
        a4_next     = a3_reg;
        a4_next.num = s0.val;
        a4_next.den = s1.val;
        a4_next.sat = a3_reg.sat | s0.sat | s1.sat;
    end

    // ------------------------------------------------------------------
    // Radial factor. A zero denominator is replaced by one in the divider
    // and the result overridden at its output.
    // ------------------------------------------------------------------
    q_t [0:0]        d2_n, d2_d, d2_q;
    logic [0:0]      d2_sat;
    logic [CW-1:0]   d2_side;
    ctx_t            c6;

    assign d2_n[0] = a4_reg.num;
    assign d2_d[0] = (a4_reg.den == '0) ? cpp_pkg::ONE_Q : a4_reg.den;

    cpp_div_bank #(.LANES(1), .SW(CW)) u_div_f (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(va4_reg),
        .n(d2_n), .d(d2_d), .side_in(CW'(a4_reg)),
        .out_valid(vd2), .q(d2_q), .sat(d2_sat), .side_out(d2_side)
    );

    always_comb
    begin
        c6 = ctx_t'(d2_side);
        if (c6.den == '0)
        begin
            c6.sat = 1'b1;
            if (c6.num > 0)
            begin
                c6.f = cpp_pkg::SAT_LIM;
            end
            else if (c6.num < 0)
            begin
                c6.f = -cpp_pkg::SAT_LIM;
            end
            else
            begin
                c6.f = '0;
            end
        end
        else
        begin
            c6.f   = d2_q[0];
            c6.sat = c6.sat | d2_sat[0];
        end
    end

    // Apply the radial factor.
    q_t [1:0]        m5_a, m5_b, m5_p;
    logic [1:0]      m5_sat;
    logic [CW-1:0]   m5_side;
    ctx_t            c7;

    assign m5_a = {c6.y, c6.x};
    assign m5_b = {c6.f, c6.f};

    cpp_mul_bank #(.LANES(2), .SW(CW)) u_mul_f (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vd2),
        .a(m5_a), .b(m5_b), .side_in(CW'(c6)),
        .out_valid(vm5), .p(m5_p), .sat(m5_sat), .side_out(m5_side)
    );

    always_comb
    begin
        c7     = ctx_t'(m5_side);
        c7.xf  = m5_p[0];
        c7.yf  = m5_p[1];
        c7.sat = c7.sat | (|m5_sat);
    end

    // Add the tangential terms in two steps.
    ctx_t a5_reg, a5_next;
    always_comb
    begin
        cpp_pkg::sres_t s0, s1;
        s0 = cpp_pkg::sat_add(c7.xf, c7.p1xy2);
        s1 = cpp_pkg::sat_add(c7.yf, c7.p2xy2);
        a5_next     = c7;
        a5_next.xa  = s0.val;
        a5_next.ya  = s1.val;
        a5_next.sat = c7.sat | s0.sat | s1.sat;
    end

    ctx_t a6_reg, a6_next;
    always_comb
    begin
        cpp_pkg::sres_t s0, s1;
        s0 = cpp_pkg::sat_add(a5_reg.xa, a5_reg.p2tx);
        s1 = cpp_pkg::sat_add(a5_reg.ya, a5_reg.p1ty);
        a6_next     = a5_reg;
        a6_next.xp  = s0.val;
        a6_next.yp  = s1.val;
        a6_next.sat = a5_reg.sat | s0.sat | s1.sat;
    end

    // Focal scaling.
    q_t [1:0]        m6_a, m6_b, m6_p;
    logic [1:0]      m6_sat;
    logic [CW-1:0]   m6_side;
    ctx_t            c8;

    assign m6_a = {fy, fx};
    assign m6_b = {a6_reg.yp, a6_reg.xp};

    cpp_mul_bank #(.LANES(2), .SW(CW)) u_mul_focal (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(va6_reg),
        .a(m6_a), .b(m6_b), .side_in(CW'(a6_reg)),
        .out_valid(vm6), .p(m6_p), .sat(m6_sat), .side_out(m6_side)
    );

    always_comb
    begin
        c8     = ctx_t'(m6_side);
        c8.mu  = m6_p[0];
        c8.mv  = m6_p[1];
        c8.sat = c8.sat | (|m6_sat);
    end

    // Principal point.
    ctx_t a7_reg, a7_next;
    always_comb
    begin
        cpp_pkg::sres_t s0, s1;
        s0 = cpp_pkg::sat_add(c8.mu, cx);
        s1 = cpp_pkg::sat_add(c8.mv, cy);
        a7_next     = c8;
        a7_next.u   = s0.val;
        a7_next.v   = s1.val;
        a7_next.sat = c8.sat | s0.sat | s1.sat;
    end

    // Magnitude plus rounding half for the Q16.16 conversion.
    ctx_t a8_reg, a8_next;
    always_comb
    begin
        a8_next    = a7_reg;
        a8_next.tu = a7_reg.u[63] ? (~a7_reg.u + 64'sd129) : (a7_reg.u + 64'sd128);
        a8_next.tv = a7_reg.v[63] ? (~a7_reg.v + 64'sd129) : (a7_reg.v + 64'sd128);
    end

    // Clamp to 32 bits, restore the sign and form the status.
    res_t a9_reg, a9_next;
    always_comb
    begin
        logic [55:0] ru, rv;
        logic        su, sv;
        logic [31:0] pu, pv;
        ru = a8_reg.tu[63:8];
        rv = a8_reg.tv[63:8];
        su = 1'b0;
        sv = 1'b0;
        if (a8_reg.u[63])
        begin
            su = ru > 56'h80000000;
            pu = su ? 32'h80000000 : 32'(-ru);
        end
        else
        begin
            su = ru > 56'h7FFFFFFF;
            pu = su ? 32'h7FFFFFFF : ru[31:0];
        end
        if (a8_reg.v[63])
        begin
            sv = rv > 56'h80000000;
            pv = sv ? 32'h80000000 : 32'(-rv);
        end
        else
        begin
            sv = rv > 56'h7FFFFFFF;
            pv = sv ? 32'h7FFFFFFF : rv[31:0];
        end
        if (a8_reg.bad)
        begin
            a9_next.u  = '0;
            a9_next.v  = '0;
            a9_next.st = cpp_pkg::ST_DEPTH;
        end
        else
        begin
            a9_next.u  = pu;
            a9_next.v  = pv;
            a9_next.st = (a8_reg.sat || su || sv) ? cpp_pkg::ST_CLAMP : cpp_pkg::ST_OK;
        end
    end

    // Payload registers of the local stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_reg <= c0_next;
            a1_reg <= a1_next;
            a2_reg <= a2_next;
            a3_reg <= a3_next;
            a4_reg <= a4_next;
            a5_reg <= a5_next;
            a6_reg <= a6_next;
            a7_reg <= a7_next;
            a8_reg <= a8_next;
            a9_reg <= a9_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry.
    // ------------------------------------------------------------------
    res_t out_reg, skid_reg;
    logic take;
    assign take = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (va9_reg)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (va9_reg)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= a9_reg;
            end
            else
            begin
                skid_reg <= a9_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.v, out_reg.u};
    assign m_tuser  = out_reg.st;

`ifndef NO_ASSERTIONS
    // A held skid beat always sits behind a valid output beat.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    // The skid only fills when the output beat was stalled.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    // A point with no positive depth gives a zero pixel.
    a_depth_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == cpp_pkg::ST_DEPTH)) |-> (m_tdata == '0))
        else $error("depth fault result carries a nonzero pixel");
`endif

endmodule
